// File: rtl/lru_key_value_cache_unit_defines.svh
// ----------------------------------------------------------------------------
// lru key-value cache assertion macros
// shared concurrent assertion forms for the cache rtl
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LKV_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("lkv: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define LKV_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("lkv: next-cycle check failed");

`endif

// File: rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// field widths, codes and sequencer states of the lru key-value cache
// ----------------------------------------------------------------------------
package lkv_pkg;

  localparam int KEY_W = 16;
  localparam int VAL_W = 16;
  localparam int CFG_W = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] NOT_FOUND = 16'hFFFF;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_STORE  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLAN,
    ST_UPD,
    ST_WRITE,
    ST_RESP
  } lkv_state_t;

endpackage

// File: rtl/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv channel interfaces
// request, response and configuration channels with valid/ready
// ----------------------------------------------------------------------------
interface lkv_req_if;
  import lkv_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [KEY_W-1:0] req_key;
  logic [VAL_W-1:0] req_value;

  modport source (output valid, output mode, output req_key, output req_value,
                  input ready);
  modport sink   (input valid, input mode, input req_key, input req_value,
                  output ready);
endinterface

interface lkv_rsp_if;
  import lkv_pkg::*;
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] read_value;
  logic             evicted;
  logic [KEY_W-1:0] evicted_key;

  modport source (output valid, output found, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input found, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

interface lkv_cfg_if;
  import lkv_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] capacity_in_use;

  modport source (output valid, output capacity_in_use, input ready);
  modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// File: rtl/lkv_ram.sv
// ----------------------------------------------------------------------------
// lkv_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lkv_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lru_key_value_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// fully associative key-value cache with least-recently-used replacement
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     word
//   -------  ---  ------------  ----------------------------------------
//   cfg      in   valid/ready   capacity_in_use (always ready)
//   req      in   valid/ready   mode, req_key, req_value
//   rsp      out  valid/ready   found, read_value, evicted, evicted_key
//
// one word at a time: a scan pass over all CAPACITY entries through the
// key/value/age rams, a plan state, then for hits and stores an age update
// pass over all entries and a write state before the response state
// lookup miss: from the plan state straight to the response state
// the response register lets the next word be accepted while rsp stalls
// synchronous reset clears valid bits, occupancy and capacity (to 16); the
// rams hold no reset and are read only where the valid bit is set
//
module lru_key_value_cache_unit #(
  parameter int CAPACITY = 16
) (
  input  logic    clk,
  input  logic    rst,
  lkv_cfg_if.sink cfg,
  lkv_req_if.sink req,
  lkv_rsp_if.source rsp
);
  import lkv_pkg::*;
  `include "lru_key_value_cache_unit_defines.svh"

  // index width at least one bit; counter also holds CAPACITY itself
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int AGE_W = IDX_W;
  localparam int OCC_W = CNT_W;
  localparam int CMP_W = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  // sequencer
  lkv_state_t state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             cnt_last;
  logic             run;
  logic             p_vld;
  logic [IDX_W-1:0] p_idx;

  // control state
  logic [CFG_W-1:0]    capacity_in_use;
  logic [OCC_W-1:0]    occupancy;
  logic [CAPACITY-1:0] valid;
  logic                out_valid;

  // captured request
  logic             mode_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // scan trackers
  logic             hit_found;
  logic [IDX_W-1:0] hit_idx;
  logic [AGE_W-1:0] hit_age;
  logic [VAL_W-1:0] hit_val;
  logic             vic_found;
  logic [IDX_W-1:0] vic_idx;
  logic [AGE_W-1:0] vic_age;
  logic [KEY_W-1:0] vic_key;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // plan results
  logic [IDX_W-1:0] slot;
  logic [AGE_W-1:0] thresh;
  logic             inc_all;
  logic             res_found;
  logic [VAL_W-1:0] res_value;
  logic             res_evicted;
  logic [KEY_W-1:0] res_evk;

  // output register
  logic             out_found;
  logic [VAL_W-1:0] out_value;
  logic             out_evicted;
  logic [KEY_W-1:0] out_evk;

  // ram ports
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic [AGE_W-1:0] age_rd;
  logic [AGE_W-1:0] age_new;
  logic             kv_we;
  logic             age_we;
  logic [IDX_W-1:0] raddr;

  // capacity clamp and eviction decision
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_eff;
  logic             evict_cond;
  logic             is_store;
  logic             entry_hit;
  logic             plan_insert;

  // ---------------------------------------------------------------------
  // entry storage
  // ---------------------------------------------------------------------
  assign raddr  = cnt[IDX_W-1:0];
  assign kv_we  = (state == ST_WRITE) && is_store;
  assign age_we = (state == ST_UPD) && p_vld;

  lkv_ram #(.DEPTH(CAPACITY), .WIDTH(KEY_W), .ADDR_W(IDX_W)) u_key_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (slot),
    .wdata (key_q),
    .raddr (raddr),
    .rdata (key_rd)
  );

  lkv_ram #(.DEPTH(CAPACITY), .WIDTH(VAL_W), .ADDR_W(IDX_W)) u_val_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (slot),
    .wdata (val_q),
    .raddr (raddr),
    .rdata (val_rd)
  );

  lkv_ram #(.DEPTH(CAPACITY), .WIDTH(AGE_W), .ADDR_W(IDX_W)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (p_idx),
    .wdata (age_new),
    .raddr (raddr),
    .rdata (age_rd)
  );

  // ---------------------------------------------------------------------
  // shared compare logic
  // ---------------------------------------------------------------------
  assign is_store  = (mode_q == MODE_STORE);
  assign entry_hit = valid[p_idx] && (key_rd == key_q);

  // capacity of zero acts as one, above CAPACITY acts as CAPACITY
  assign cap_ext = CMP_W'(capacity_in_use);
  always_comb begin
    priority if (capacity_in_use == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      cap_eff = CMP_W'(CAPACITY);
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign evict_cond  = (CMP_W'(occupancy) >= cap_eff);
  assign plan_insert = (state == ST_PLAN) && is_store && !hit_found;

  // age update: touched or inserted slot goes to zero, younger valid
  // entries (or all valid entries on insert) age by one
  always_comb begin
    priority if (p_idx == slot) begin
      age_new = '0;
    end else if (valid[p_idx] && (inc_all || (age_rd < thresh))) begin
      age_new = AGE_W'(age_rd + AGE_W'(1));
    end else begin
      age_new = age_rd;
    end
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  assign cnt_last = (cnt == CNT_W'(CAPACITY));
  assign run      = ((state == ST_SCAN) || (state == ST_UPD)) && !cnt_last;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_last) state_next = ST_PLAN;
      end
      ST_PLAN: begin
        if (!is_store && !hit_found) state_next = ST_RESP;
        else state_next = ST_UPD;
      end
      ST_UPD: begin
        if (cnt_last) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cnt             <= '0;
      p_vld           <= 1'b0;
      capacity_in_use <= CAP_RESET;
      occupancy       <= '0;
      valid           <= '0;
      out_valid       <= 1'b0;
      hit_found       <= 1'b0;
      vic_found       <= 1'b0;
      free_found      <= 1'b0;
    end else begin
      state <= state_next;
      p_vld <= run;
      cnt   <= run ? CNT_W'(cnt + 1'b1) : '0;

      if (cfg.valid) begin
        capacity_in_use <= cfg.capacity_in_use;
      end

      // a new response word replaces the one leaving in the same cycle
      if ((state == ST_RESP) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            hit_found  <= 1'b0;
            vic_found  <= 1'b0;
            free_found <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (p_vld) begin
            if (entry_hit && !hit_found) hit_found <= 1'b1;
            if (valid[p_idx]) vic_found <= 1'b1;
            if (!valid[p_idx]) free_found <= 1'b1;
          end
        end
        ST_PLAN: begin
          // insert without eviction grows occupancy; eviction keeps it
          if (is_store && !hit_found && !evict_cond) begin
            occupancy <= OCC_W'(occupancy + 1'b1);
          end
        end
        ST_UPD: begin
        end
        ST_WRITE: begin
          if (is_store) valid[slot] <= 1'b1;
        end
        ST_RESP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    p_idx <= cnt[IDX_W-1:0];

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          mode_q <= req.mode;
          key_q  <= req.req_key;
          val_q  <= req.req_value;
        end
      end
      ST_SCAN: begin
        if (p_vld) begin
          // first matching valid entry
          if (entry_hit && !hit_found) begin
            hit_idx <= p_idx;
            hit_age <= age_rd;
            hit_val <= val_rd;
          end
          // oldest valid entry is the eviction candidate
          if (valid[p_idx] && (!vic_found || (age_rd > vic_age))) begin
            vic_idx <= p_idx;
            vic_age <= age_rd;
            vic_key <= key_rd;
          end
          // lowest free slot
          if (!valid[p_idx] && !free_found) begin
            free_idx <= p_idx;
          end
        end
      end
      ST_PLAN: begin
        priority if (hit_found) begin
          // hit on lookup or store: touch the entry
          res_found   <= 1'b1;
          res_value   <= is_store ? val_q : hit_val;
          res_evicted <= 1'b0;
          res_evk     <= '0;
          slot        <= hit_idx;
          thresh      <= hit_age;
          inc_all     <= 1'b0;
        end else if (!is_store) begin
          // lookup miss
          res_found   <= 1'b0;
          res_value   <= NOT_FOUND;
          res_evicted <= 1'b0;
          res_evk     <= '0;
          slot        <= hit_idx;
          thresh      <= '0;
          inc_all     <= 1'b0;
        end else begin
          // store of a new key: evict the oldest when full
          res_found   <= 1'b0;
          res_value   <= val_q;
          res_evicted <= evict_cond;
          res_evk     <= evict_cond ? vic_key : '0;
          slot        <= evict_cond ? vic_idx : free_idx;
          thresh      <= '0;
          inc_all     <= 1'b1;
        end
      end
      ST_UPD: begin
      end
      ST_WRITE: begin
      end
      ST_RESP: begin
        if (!out_valid || rsp.ready) begin
          out_found   <= res_found;
          out_value   <= res_value;
          out_evicted <= res_evicted;
          out_evk     <= res_evk;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.read_value  = out_value;
  assign rsp.evicted     = out_evicted;
  assign rsp.evicted_key = out_evk;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `LKV_ASSERT_IMPLY(a_occ_bound, clk, rst, 1'b1, occupancy <= OCC_W'(CAPACITY))
  `LKV_ASSERT_NEXT(a_accept_scan, clk, rst, req.valid && req.ready, state == ST_SCAN)
  `LKV_ASSERT_IMPLY(a_victim_exists, clk, rst, plan_insert && evict_cond, vic_found)
  `LKV_ASSERT_IMPLY(a_free_exists, clk, rst, plan_insert && !evict_cond, free_found)

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// lru key-value cache testbench
// drives lookups and stores through the request channel, predicts every
// response with a shadow lru store and checks each response word field by
// field, over a series of capacity settings with random stalls on both sides
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lkv_pkg::*;

  localparam int CACHE_DEPTH = 16;
  // worst accept-to-response time of one word
  localparam int WORD_LATENCY = 2 * CACHE_DEPTH + 6;
  // long response hold-off that backs the block up into its request channel
  localparam int HOLD_CYCLES = 300;
  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE = 24;
  localparam int PHASE_WORDS = 60;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } cache_reply_t;

  // --------------------------------------------------------------------------
  // scoreboard: shadow copy of the cache plus the queue of awaited responses
  // --------------------------------------------------------------------------
  class lru_scoreboard;
    logic [KEY_W-1:0] slot_key   [CACHE_DEPTH];
    logic [VAL_W-1:0] slot_value [CACHE_DEPTH];
    bit               slot_valid [CACHE_DEPTH];
    bit [3:0]         slot_age   [CACHE_DEPTH];
    int               fill_count;
    logic [CFG_W-1:0] capacity;
    cache_reply_t     awaited_replies[$];
    int               mismatches;

    function new();
      foreach (slot_valid[i]) begin
        slot_key[i]   = '0;
        slot_value[i] = '0;
        slot_valid[i] = 1'b0;
        slot_age[i]   = '0;
      end
      fill_count = 0;
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CFG_W-1:0] value);
      capacity = value;
    endfunction

    function int outstanding();
      return awaited_replies.size();
    endfunction

    // zero acts as one, anything above the depth acts as the depth
    function int capacity_limit();
      if (capacity == 0) return 1;
      if (capacity > CACHE_DEPTH) return CACHE_DEPTH;
      return int'(capacity);
    endfunction

    // make slot s most recent: valid entries younger than s age by one
    function void promote(int s);
      bit [3:0] a;
      a = slot_age[s];
      for (int i = 0; i < CACHE_DEPTH; i++)
        if (slot_valid[i] && i != s && slot_age[i] < a) slot_age[i]++;
      slot_age[s] = '0;
    endfunction

    function void note_request(logic mode, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value);
      cache_reply_t reply;
      int hit;
      int slot;
      reply = '{found: 1'b0, read_value: NOT_FOUND, evicted: 1'b0, evicted_key: '0};
      hit = -1;
      slot = -1;
      for (int i = 0; i < CACHE_DEPTH; i++)
        if (hit < 0 && slot_valid[i] && slot_key[i] == key) hit = i;

      if (mode == MODE_LOOKUP) begin
        if (hit >= 0) begin
          reply.found = 1'b1;
          reply.read_value = slot_value[hit];
          promote(hit);
        end
      end else begin
        reply.read_value = value;
        if (hit >= 0) begin
          reply.found = 1'b1;
          slot_value[hit] = value;
          promote(hit);
        end else begin
          if (fill_count >= capacity_limit()) begin
            // victim is the valid entry with the greatest age
            for (int i = 0; i < CACHE_DEPTH; i++)
              if (slot_valid[i] && (slot < 0 || slot_age[i] > slot_age[slot])) slot = i;
            if (slot >= 0) begin
              reply.evicted = 1'b1;
              reply.evicted_key = slot_key[slot];
              slot_valid[slot] = 1'b0;
              fill_count--;
            end
          end
          if (slot < 0)
            for (int i = 0; i < CACHE_DEPTH; i++)
              if (slot < 0 && !slot_valid[i]) slot = i;
          if (slot >= 0) begin
            for (int i = 0; i < CACHE_DEPTH; i++)
              if (slot_valid[i]) slot_age[i]++;
            slot_key[slot]   = key;
            slot_value[slot] = value;
            slot_valid[slot] = 1'b1;
            slot_age[slot]   = '0;
            fill_count++;
          end
        end
      end
      awaited_replies.push_back(reply);
    endfunction

    function void compare_field(string label, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(cache_reply_t got);
      cache_reply_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: response word with nothing awaited: expected none, actual %h",
                 $time, got);
        mismatches++;
        return;
      end
      want = awaited_replies.pop_front();
      compare_field("found", 16'(want.found), 16'(got.found));
      compare_field("read_value", want.read_value, got.read_value);
      compare_field("evicted", 16'(want.evicted), 16'(got.evicted));
      compare_field("evicted_key", want.evicted_key, got.evicted_key);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst;

  lkv_cfg_if cfg_ch ();
  lkv_req_if req_ch ();
  lkv_rsp_if rsp_ch ();

  lru_key_value_cache_unit #(
    .CAPACITY(CACHE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  lru_scoreboard sb;

  // shared between the stimulus and the response sink
  bit no_idle;        // calm stretch: neither side idles
  bit hold_replies;   // one-shot request for the long response hold-off

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  // --------------------------------------------------------------------------
  // channel monitor: sample every handshake at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      // responses first: a word accepted now can never answer itself
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response('{found: rsp_ch.found, read_value: rsp_ch.read_value,
                            evicted: rsp_ch.evicted, evicted_key: rsp_ch.evicted_key});
      if (cfg_ch.valid && cfg_ch.ready) sb.set_capacity(cfg_ch.capacity_in_use);
      if (req_ch.valid && req_ch.ready)
        sb.note_request(req_ch.mode, req_ch.req_key, req_ch.req_value);
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: ends the run when no channel moves a word for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // response sink: random ready, calm stretches, and the long hold-off
  // counted here so the sender keeps offering words meanwhile
  // --------------------------------------------------------------------------
  initial begin : reply_sink
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_replies) begin
        hold_replies = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (no_idle) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= 30);
      end
    end
  end

  // --------------------------------------------------------------------------
  // request and configuration drivers
  // --------------------------------------------------------------------------

  // offer one word, optionally after an idle gap; returns at the accepting
  // edge with valid still high so back-to-back words need no second update
  task automatic send_request(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(99) < 30) begin
      // mostly short gaps, sometimes one that spans a whole word of work
      if ($urandom_range(3) == 0) begin
        gap = $urandom_range(WORD_LATENCY + 8, 1);
      end else begin
        gap = $urandom_range(3, 1);
      end
    end
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.mode      <= mode;
    req_ch.req_key   <= key;
    req_ch.req_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait until every awaited response has come back
  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // capacity is only changed with the block idle
  task automatic write_capacity(logic [CFG_W-1:0] value);
    drain_replies();
    cfg_ch.valid           <= 1'b1;
    cfg_ch.capacity_in_use <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one capacity setting with random traffic over a key pool a little larger
  // than the capacity, so hits, updates and evictions all stay frequent
  task automatic run_random_phase(logic [CFG_W-1:0] cap, bit calm, bit hold);
    int span;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    write_capacity(cap);
    span = sb.capacity_limit() + $urandom_range(6, 1);
    if (span > POOL_SIZE) span = POOL_SIZE;
    no_idle = calm;
    if (hold) hold_replies = 1'b1;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      if ($urandom_range(99) < 15) begin
        key = KEY_W'($urandom_range(16'hFFFF));
      end else begin
        key = key_pool[$urandom_range(span - 1)];
      end
      case ($urandom_range(9))
        0: value = '0;
        1: value = 16'hFFFF;
        default: value = VAL_W'($urandom_range(16'hFFFF));
      endcase
      send_request($urandom_range(1) ? MODE_STORE : MODE_LOOKUP, key, value);
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    sb = new();
    no_idle = 1'b0;
    hold_replies = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_LOOKUP;
    req_ch.req_key = '0;
    req_ch.req_value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.capacity_in_use = CAP_RESET;

    // pool holds both key extremes plus random keys
    key_pool[0] = '0;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom_range(16'hFFFF));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset capacity, key and value extremes, hit, miss, update
    send_request(MODE_LOOKUP, 16'h0000, 16'h5A5A);   // lookup on empty cache
    send_request(MODE_STORE,  16'h0000, 16'h0000);
    send_request(MODE_STORE,  16'hFFFF, 16'hFFFF);
    send_request(MODE_LOOKUP, 16'h0000, 16'hFFFF);   // hit, value ignored
    send_request(MODE_LOOKUP, 16'hFFFF, 16'h0000);   // hit on the marker value
    send_request(MODE_STORE,  16'h0000, 16'h1234);   // update of a present key
    send_request(MODE_LOOKUP, 16'h1234, 16'hA5A5);   // miss
    send_request(MODE_LOOKUP, 16'h0000, 16'h0001);

    // zero capacity acts as one, already below the occupancy
    write_capacity(5'd0);
    send_request(MODE_STORE,  16'h0005, 16'h0050);   // evicts the least recent
    send_request(MODE_LOOKUP, 16'hFFFF, 16'h0000);   // evicted key now misses
    send_request(MODE_STORE,  16'h0006, 16'h0060);
    send_request(MODE_STORE,  16'h0006, 16'h0007);   // update, no eviction

    // capacity above occupancy: new keys fill the lowest free slots, then evict
    write_capacity(5'd4);
    send_request(MODE_STORE,  16'h0008, 16'h0080);
    send_request(MODE_STORE,  16'h0009, 16'h0090);
    send_request(MODE_STORE,  16'h000A, 16'h00A0);
    send_request(MODE_LOOKUP, 16'h0005, 16'h0000);
    send_request(MODE_STORE,  16'h000B, 16'h00B0);

    // out-of-range capacity acts as the full depth
    write_capacity(5'd31);
    send_request(MODE_STORE,  16'h000C, 16'h00C0);
    send_request(MODE_LOOKUP, 16'h000B, 16'h0000);
    send_request(MODE_LOOKUP, 16'hFFFF, 16'hFFFF);

    // random phases; occupancy only grows, so the settings first rise from small ones
    run_random_phase(5'd2, 1'b0, 1'b0);
    run_random_phase(5'd5, 1'b0, 1'b0);
    run_random_phase(5'd9, 1'b0, 1'b1);              // long response hold-off
    run_random_phase(5'd17, 1'b1, 1'b0);             // calm stretch
    run_random_phase(5'd16, 1'b0, 1'b0);
    run_random_phase(5'd1, 1'b0, 1'b0);
    run_random_phase(5'd31, 1'b0, 1'b0);
    run_random_phase(CFG_W'($urandom_range(31)), 1'b0, 1'b0);

    // let everything come back, then watch for stray words a while longer
    drain_replies();
    repeat (WORD_LATENCY + 10) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/lkv_pkg.sv
rtl/lkv_if.sv
rtl/lkv_ram.sv
rtl/lru_key_value_cache_unit.sv
verif/testbench.sv
